// ----- rtl/smrp_pkg.sv -----
// ----------------------------------------------------------------------------
// smrp_pkg
// Shared types, phase codes and helpers for the matrix record parser.
// ----------------------------------------------------------------------------
package smrp_pkg;

    localparam int VAL_W   = 31;
    localparam int WID_W   = 5;
    localparam int NVAL    = 6;
    localparam int TDATA_W = 200;

    // record phases
    localparam logic [3:0] PH_SCALE_FLAG = 4'd0;
    localparam logic [3:0] PH_SCALE_W    = 4'd1;
    localparam logic [3:0] PH_SCALE_X    = 4'd2;
    localparam logic [3:0] PH_SCALE_Y    = 4'd3;
    localparam logic [3:0] PH_ROT_FLAG   = 4'd4;
    localparam logic [3:0] PH_ROT_W      = 4'd5;
    localparam logic [3:0] PH_SKEW0      = 4'd6;
    localparam logic [3:0] PH_SKEW1      = 4'd7;
    localparam logic [3:0] PH_TRANS_W    = 4'd8;
    localparam logic [3:0] PH_TRANS_X    = 4'd9;
    localparam logic [3:0] PH_TRANS_Y    = 4'd10;
    localparam logic [3:0] PH_DONE       = 4'd11;

    typedef logic [NVAL-1:0][VAL_W-1:0] val_arr_t;

    typedef struct packed {
        logic step;
        logic bit_in;
        logic clear;
    } eng_ctrl_t;

    typedef struct packed {
        logic done;
        logic skip;
    } eng_stat_t;

    // sign-extend the low w bits of v to 31 bits; width zero gives zero
    function automatic logic [VAL_W-1:0] sext31(input logic [VAL_W-1:0] v,
                                                input logic [WID_W-1:0] w);
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] sh;
        logic             sign;
        low  = {VAL_W{1'b1}} >> (5'd31 - w);
        sh   = v >> (w - 5'd1);
        sign = sh[0];
        if (w == '0) begin
            return '0;
        end
        return (v & low) | (sign ? ~low : '0);
    endfunction

endpackage

// ----- rtl/smrp_bit_engine.sv -----
// ----------------------------------------------------------------------------
// smrp_bit_engine
// Shared bit-step unit: shifts one record bit per step into the field
// accumulator, decodes widths and captures sign-extended values.
// ----------------------------------------------------------------------------
module smrp_bit_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  smrp_pkg::eng_ctrl_t ctrl,
    output smrp_pkg::eng_stat_t stat,
    output smrp_pkg::val_arr_t  values,
    output logic [1:0]          flags
);

    logic [3:0]                   ph_reg, ph_next;
    logic [smrp_pkg::WID_W-1:0]   rem_reg, rem_next;
    logic [smrp_pkg::WID_W-1:0]   wid_reg, wid_next;
    logic [smrp_pkg::VAL_W-1:0]   acc_reg, acc_next;
    smrp_pkg::val_arr_t           val_reg, val_next;
    logic [1:0]                   flg_reg, flg_next;

    logic is_val;
    logic is_flag;

    function automatic logic [2:0] slot_of(input logic [3:0] ph);
        logic [2:0] s;
        unique case (ph)
            smrp_pkg::PH_SCALE_X: s = 3'd0;
            smrp_pkg::PH_SCALE_Y: s = 3'd1;
            smrp_pkg::PH_SKEW0:   s = 3'd2;
            smrp_pkg::PH_SKEW1:   s = 3'd3;
            smrp_pkg::PH_TRANS_X: s = 3'd4;
            default:              s = 3'd5;
        endcase
        return s;
    endfunction

    assign is_val  = (ph_reg inside {smrp_pkg::PH_SCALE_X, smrp_pkg::PH_SCALE_Y,
                                     smrp_pkg::PH_SKEW0, smrp_pkg::PH_SKEW1,
                                     smrp_pkg::PH_TRANS_X, smrp_pkg::PH_TRANS_Y});
    assign is_flag = (ph_reg == smrp_pkg::PH_SCALE_FLAG) || (ph_reg == smrp_pkg::PH_ROT_FLAG);

    assign stat.done = (ph_reg == smrp_pkg::PH_DONE);
    assign stat.skip = is_val && (rem_reg == '0);
    assign values    = val_reg;
    assign flags     = flg_reg;

    always_comb begin
        logic                       fin;
        logic [smrp_pkg::VAL_W-1:0] accv;
        logic [smrp_pkg::VAL_W-1:0] acc_sh;
        logic [smrp_pkg::WID_W-1:0] rem_dec;
        fin      = 1'b0;
        accv     = acc_reg;
        acc_sh   = {acc_reg[smrp_pkg::VAL_W-2:0], ctrl.bit_in};
        rem_dec  = rem_reg - 5'd1;
        ph_next  = ph_reg;
        rem_next = rem_reg;
        wid_next = wid_reg;
        acc_next = acc_reg;
        val_next = val_reg;
        flg_next = flg_reg;
        if (ctrl.clear) begin
            ph_next  = smrp_pkg::PH_SCALE_FLAG;
            rem_next = '0;
            wid_next = '0;
            acc_next = '0;
            val_next = '0;
            flg_next = '0;
        end else if (ctrl.step && !stat.done) begin
            if (is_flag) begin
                acc_next = '0;
                rem_next = 5'd5;
                if (ctrl.bit_in) begin
                    ph_next = ph_reg + 4'd1;
                    if (ph_reg == smrp_pkg::PH_SCALE_FLAG) begin
                        flg_next[0] = 1'b1;
                    end else begin
                        flg_next[1] = 1'b1;
                    end
                end else begin
                    ph_next = ph_reg + 4'd4;
                end
            end else if (stat.skip) begin
                // zero-width value: no bit consumed
                fin  = 1'b1;
                accv = acc_reg;
            end else if (rem_dec == '0) begin
                if (is_val) begin
                    fin  = 1'b1;
                    accv = acc_sh;
                end else begin
                    wid_next = acc_sh[smrp_pkg::WID_W-1:0];
                    rem_next = acc_sh[smrp_pkg::WID_W-1:0];
                    acc_next = '0;
                    ph_next  = ph_reg + 4'd1;
                end
            end else begin
                acc_next = acc_sh;
                rem_next = rem_dec;
            end
            if (fin) begin
                val_next[slot_of(ph_reg)] = smrp_pkg::sext31(accv, wid_reg);
                acc_next = '0;
                unique case (ph_reg)
                    smrp_pkg::PH_SCALE_X, smrp_pkg::PH_SKEW0, smrp_pkg::PH_TRANS_X: begin
                        ph_next  = ph_reg + 4'd1;
                        rem_next = wid_reg;
                    end
                    smrp_pkg::PH_SCALE_Y: begin
                        ph_next  = smrp_pkg::PH_ROT_FLAG;
                        rem_next = 5'd1;
                    end
                    smrp_pkg::PH_SKEW1: begin
                        ph_next  = smrp_pkg::PH_TRANS_W;
                        rem_next = 5'd5;
                    end
                    default: begin
                        ph_next  = smrp_pkg::PH_DONE;
                        rem_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= smrp_pkg::PH_SCALE_FLAG;
            rem_reg <= '0;
            wid_reg <= '0;
            acc_reg <= '0;
            val_reg <= '0;
            flg_reg <= '0;
        end else begin
            ph_reg  <= ph_next;
            rem_reg <= rem_next;
            wid_reg <= wid_next;
            acc_reg <= acc_next;
            val_reg <= val_next;
            flg_reg <= flg_next;
        end
    end

endmodule

// ----- rtl/smrp_seq.sv -----
// ----------------------------------------------------------------------------
// smrp_seq
// Byte sequencer: takes input transactions, feeds bits MSB first to the
// bit engine, zero-fills after an early end, and hands records to output.
// ----------------------------------------------------------------------------
module smrp_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  smrp_pkg::eng_stat_t stat,
    output smrp_pkg::eng_ctrl_t ctrl,
    input  logic                out_free,
    output logic                emit,
    output logic [4:0]          byte_count,
    output logic                trunc
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [7:0] sh_reg, sh_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       eod_reg, eod_next;
    logic [4:0] bc_reg, bc_next;
    logic       trunc_reg, trunc_next;

    assign byte_count = bc_reg;
    assign trunc      = trunc_reg;

    always_comb begin
        state_next  = state_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        eod_next    = eod_reg;
        bc_next     = bc_reg;
        trunc_next  = trunc_reg;
        s_tready    = 1'b0;
        emit        = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.bit_in = 1'b0;
        ctrl.clear  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sh_next    = s_tdata;
                    cnt_next   = 4'd8;
                    eod_next   = s_tlast;
                    bc_next    = bc_reg + 5'd1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (stat.done) begin
                    state_next = S_EMIT;
                end else if (stat.skip) begin
                    ctrl.step = 1'b1;
                end else if (cnt_reg != '0) begin
                    ctrl.step   = 1'b1;
                    ctrl.bit_in = sh_reg[7];
                    sh_next     = {sh_reg[6:0], 1'b0};
                    cnt_next    = cnt_reg - 4'd1;
                end else if (eod_reg) begin
                    // early end: feed a zero byte
                    sh_next    = '0;
                    cnt_next   = 4'd8;
                    bc_next    = bc_reg + 5'd1;
                    trunc_next = 1'b1;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    ctrl.clear = 1'b1;
                    bc_next    = '0;
                    trunc_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            eod_reg   <= 1'b0;
            bc_reg    <= '0;
            trunc_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eod_reg   <= eod_next;
            bc_reg    <= bc_next;
            trunc_reg <= trunc_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

endmodule

// ----- rtl/swf_matrix_record_parser_top.sv -----
// ----------------------------------------------------------------------------
// swf_matrix_record_parser_top
// Bit-serial parser for matrix records: scale, rotate and translate pairs.
// ----------------------------------------------------------------------------
// Input channel (s_): one record byte per transaction in s_tdata[7:0];
// s_tlast marks the final byte, after which missing bits are zero-filled.
// Output channel (m_): one transaction per completed record carrying the
// presence flags, six values, the byte count and the truncation flag.
// Each accepted byte is worked through one bit per cycle by the shared bit
// engine, with a step for each zero-width value skipped between bits; the
// input stays not ready until the byte is used up and the sequencer is idle.
// After its last bit step or skip, a record passes the done phase and the
// sequencer's emit state, which waits for room, to reach the output register.
// Each zero-filled byte after an early end is stepped through the same way.
// Leftover bits of a byte after a record completes are dropped.
// The result sits in an output register; a stalled receiver holds only
// that register, and parsing of the next record goes on until a second
// result is ready, which then waits for the register to drain.
// Reset (aresetn low, synchronous) clears the record and empties the
// output register.
// ----------------------------------------------------------------------------
module swf_matrix_record_parser_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // data_byte
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // has_scale, scale_x, scale_y, has_rotate, rotate_skew0, rotate_skew1,
    // translate_x, translate_y, bytes_used, truncated, zero pad
    output logic [smrp_pkg::TDATA_W-1:0] m_tdata
);

    smrp_pkg::eng_ctrl_t ctrl;
    smrp_pkg::eng_stat_t stat;
    smrp_pkg::val_arr_t  values;
    logic [1:0]          flags;
    logic                emit;
    logic                out_free;
    logic [4:0]          byte_count;
    logic                trunc;

    logic                         out_valid_reg, out_valid_next;
    logic [smrp_pkg::TDATA_W-1:0] out_data_reg, out_data_next;

    smrp_bit_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .values  (values),
        .flags   (flags)
    );

    smrp_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .stat       (stat),
        .ctrl       (ctrl),
        .out_free   (out_free),
        .emit       (emit),
        .byte_count (byte_count),
        .trunc      (trunc)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {6'b0, trunc, byte_count,
                              values[5], values[4], values[3], values[2], flags[1],
                              values[1], values[0], flags[0]};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_no_ready_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && stat.done))
        else $error("input ready with a finished record pending");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> !stat.done && (flags == 2'b00))
        else $error("record not cleared after hand-over");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> byte_count != 5'd0)
        else $error("record handed over with zero byte count");

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

endmodule

// ----- tb/tb_swf_matrix_record_parser_top.sv -----
// ----------------------------------------------------------------------------
// tb_swf_matrix_record_parser_top
// Self-checking bench for the matrix record parser. Record bytes are built
// from chosen field values, some cut short or ended by tlast, and mixed with
// raw byte noise. A bit-level parser model in the bench predicts each record
// and every output transaction is checked field by field. Phases vary the
// sender and receiver idling, and one long receiver hold-off backs the
// block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_swf_matrix_record_parser_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } byte_item_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata = 8'd0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [smrp_pkg::TDATA_W-1:0]  m_tdata;

    byte_item_t                    pend_q[$];
    logic [smrp_pkg::TDATA_W-1:0]  matrix_q[$];
    bit                            rec_bits[$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    bit  in_taken = 1'b0;
    int  cycles = 0;
    int  errors = 0;
    int  bytes_in = 0;
    int  records_seen = 0;
    int  trunc_seen = 0;
    int  stall_cycles = 0;

    // parser state as the bench sees it
    logic [3:0]  pr_phase;
    logic [4:0]  pr_left;
    logic [4:0]  pr_width;
    logic [30:0] pr_acc;
    logic [30:0] pr_val [6];
    logic [1:0]  pr_flags;
    logic [4:0]  pr_nbytes;

    swf_matrix_record_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ---------------- predictor ----------------

    task automatic clear_parse();
        pr_phase  = smrp_pkg::PH_SCALE_FLAG;
        pr_left   = '0;
        pr_width  = '0;
        pr_acc    = '0;
        pr_flags  = '0;
        pr_nbytes = '0;
        for (int i = 0; i < 6; i++) pr_val[i] = '0;
    endtask

    function automatic logic [30:0] widen(input logic [30:0] v, input logic [4:0] w);
        logic signed [30:0] t;
        if (w == 5'd0) return '0;
        t = v << (31 - w);
        return t >>> (31 - w);
    endfunction

    function automatic int slot_of(input logic [3:0] ph);
        case (ph)
            smrp_pkg::PH_SCALE_X: return 0;
            smrp_pkg::PH_SCALE_Y: return 1;
            smrp_pkg::PH_SKEW0:   return 2;
            smrp_pkg::PH_SKEW1:   return 3;
            smrp_pkg::PH_TRANS_X: return 4;
            default:              return 5;
        endcase
    endfunction

    // store the value, move on, and skip over zero-width values
    task automatic close_value();
        bit more;
        more = 1'b1;
        while (more) begin
            pr_val[slot_of(pr_phase)] = widen(pr_acc, pr_width);
            pr_acc = '0;
            more = 1'b0;
            case (pr_phase)
                smrp_pkg::PH_SCALE_X, smrp_pkg::PH_SKEW0, smrp_pkg::PH_TRANS_X: begin
                    pr_phase = pr_phase + 4'd1;
                    pr_left  = pr_width;
                    more     = (pr_left == 5'd0);
                end
                smrp_pkg::PH_SCALE_Y: begin
                    pr_phase = smrp_pkg::PH_ROT_FLAG;
                    pr_left  = 5'd1;
                end
                smrp_pkg::PH_SKEW1: begin
                    pr_phase = smrp_pkg::PH_TRANS_W;
                    pr_left  = 5'd5;
                end
                default: begin
                    pr_phase = smrp_pkg::PH_DONE;
                    pr_left  = '0;
                end
            endcase
        end
    endtask

    task automatic take_bit(input bit b);
        bit is_val;
        if (pr_phase >= smrp_pkg::PH_DONE) return;
        if (pr_phase == smrp_pkg::PH_SCALE_FLAG || pr_phase == smrp_pkg::PH_ROT_FLAG) begin
            pr_acc = '0;
            if (b) begin
                pr_flags = pr_flags |
                           ((pr_phase == smrp_pkg::PH_SCALE_FLAG) ? 2'b01 : 2'b10);
                pr_phase = pr_phase + 4'd1;
            end else begin
                pr_phase = pr_phase + 4'd4;
            end
            pr_left = 5'd5;
            return;
        end
        pr_acc = {pr_acc[29:0], b};
        if (pr_left != 5'd0) pr_left = pr_left - 5'd1;
        if (pr_left != 5'd0) return;
        is_val = (pr_phase == smrp_pkg::PH_SCALE_X || pr_phase == smrp_pkg::PH_SCALE_Y ||
                  pr_phase == smrp_pkg::PH_SKEW0   || pr_phase == smrp_pkg::PH_SKEW1   ||
                  pr_phase == smrp_pkg::PH_TRANS_X || pr_phase == smrp_pkg::PH_TRANS_Y);
        if (is_val) begin
            close_value();
        end else begin
            pr_width = pr_acc[4:0];
            pr_acc   = '0;
            pr_phase = pr_phase + 4'd1;
            pr_left  = pr_width;
            if (pr_left == 5'd0) close_value();
        end
    endtask

    task automatic take_byte(input logic [7:0] v);
        pr_nbytes = pr_nbytes + 5'd1;
        for (int i = 7; i >= 0; i--) begin
            if (pr_phase < smrp_pkg::PH_DONE) take_bit(v[i]);
        end
    endtask

    task automatic parse_byte(input logic [7:0] v, input logic eod);
        logic trunc;
        trunc = 1'b0;
        take_byte(v);
        if (pr_phase < smrp_pkg::PH_DONE) begin
            if (!eod) return;
            trunc = 1'b1;
            while (pr_phase < smrp_pkg::PH_DONE) take_byte(8'd0);
        end
        matrix_q.push_back({6'd0, trunc, pr_nbytes, pr_val[5], pr_val[4], pr_val[3],
                            pr_val[2], pr_flags[1], pr_val[1], pr_val[0], pr_flags[0]});
        if (trunc) trunc_seen++;
        clear_parse();
    endtask

    task automatic check_matrix(input logic [smrp_pkg::TDATA_W-1:0] got);
        logic [smrp_pkg::TDATA_W-1:0] want;
        logic [smrp_pkg::TDATA_W-1:0] mask;
        logic [smrp_pkg::TDATA_W-1:0] a;
        logic [smrp_pkg::TDATA_W-1:0] b;
        int                           lo;
        int                           w;
        string                        nm;
        if (matrix_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transaction, got %h", $time, got);
            return;
        end
        want = matrix_q.pop_front();
        for (int i = 0; i < 10; i++) begin
            case (i)
                0: begin lo = 0;   w = 1;  nm = "has_scale";    end
                1: begin lo = 1;   w = 31; nm = "scale_x";      end
                2: begin lo = 32;  w = 31; nm = "scale_y";      end
                3: begin lo = 63;  w = 1;  nm = "has_rotate";   end
                4: begin lo = 64;  w = 31; nm = "rotate_skew0"; end
                5: begin lo = 95;  w = 31; nm = "rotate_skew1"; end
                6: begin lo = 126; w = 31; nm = "translate_x";  end
                7: begin lo = 157; w = 31; nm = "translate_y";  end
                8: begin lo = 188; w = 5;  nm = "bytes_used";   end
                default: begin lo = 193; w = 1; nm = "truncated"; end
            endcase
            mask = ({{(smrp_pkg::TDATA_W-1){1'b0}}, 1'b1} << w) - 1'b1;
            a = (want >> lo) & mask;
            b = (got >> lo) & mask;
            if (a !== b) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, nm,
                         a[30:0], b[30:0]);
            end
        end
        records_seen++;
    endtask

    // ---------------- driver and monitor ----------------

    always @(negedge aclk) begin
        byte_item_t nx;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nx = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nx.data;
                s_tlast  <= nx.eod;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
                bytes_in++;
                in_taken = 1'b1;
            end
            if (s_tvalid && !s_tready && hold_cnt != 0) stall_cycles++;
            if (m_tvalid && m_tready) check_matrix(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_byte(input logic [7:0] v, input logic eod);
        byte_item_t it;
        it.data = v;
        it.eod  = eod;
        pend_q.push_back(it);
    endtask

    task automatic push_bits(input logic [30:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) rec_bits.push_back(v[i]);
    endtask

    // build one record; cut drops trailing bytes and ends the stream early
    task automatic add_record(input bit hs, input logic [4:0] ws,
                              input logic [30:0] sx, input logic [30:0] sy,
                              input bit hr, input logic [4:0] wr,
                              input logic [30:0] r0, input logic [30:0] r1,
                              input logic [4:0] wt,
                              input logic [30:0] tx, input logic [30:0] ty,
                              input int cut, input bit end_flag);
        int         nb;
        int         keep;
        logic [7:0] v;
        rec_bits.delete();
        rec_bits.push_back(hs);
        if (hs) begin
            push_bits(31'(ws), 5);
            push_bits(sx, int'(ws));
            push_bits(sy, int'(ws));
        end
        rec_bits.push_back(hr);
        if (hr) begin
            push_bits(31'(wr), 5);
            push_bits(r0, int'(wr));
            push_bits(r1, int'(wr));
        end
        push_bits(31'(wt), 5);
        push_bits(tx, int'(wt));
        push_bits(ty, int'(wt));
        while (rec_bits.size() % 8 != 0) rec_bits.push_back(1'($urandom_range(1)));
        nb = rec_bits.size() / 8;
        if (cut > nb - 1) cut = nb - 1;
        keep = nb - cut;
        for (int i = 0; i < keep; i++) begin
            for (int j = 0; j < 8; j++) v[7-j] = rec_bits[i*8 + j];
            push_byte(v, (i == keep - 1) && (cut > 0 || end_flag));
        end
    endtask

    function automatic logic [4:0] pick_width();
        if ($urandom_range(9) == 0) return 5'($urandom_range(31));
        return 5'($urandom_range(10));
    endfunction

    task automatic run_random(input int idle, input int stall, input int n, input bit hold);
        int stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        hold_req  = hold;
        stop_at   = bytes_in + pend_q.size() + n;
        while (bytes_in + pend_q.size() < stop_at) begin
            if ($urandom_range(99) < 80) begin
                add_record(1'($urandom_range(1)), pick_width(),
                           31'($urandom), 31'($urandom),
                           1'($urandom_range(1)), pick_width(),
                           31'($urandom), 31'($urandom),
                           pick_width(), 31'($urandom), 31'($urandom),
                           ($urandom_range(9) == 0) ? $urandom_range(1, 8) : 0,
                           $urandom_range(4) == 0);
            end else begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom), $urandom_range(7) == 0);
            end
        end
        while (pend_q.size() != 0 || s_tvalid || matrix_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        clear_parse();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed records
        push_byte(8'h00, 1'b0);     // shortest record: no pairs, translate width zero
        push_byte(8'hFF, 1'b1);     // widest scale width, almost all zero-filled
        push_byte(8'h00, 1'b1);     // end flag on a byte that completes the record
        add_record(1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_record(0, 0, 0, 0, 0, 0, 0, 0, 31, 31'h40000000, 31'h3FFFFFFF, 0, 0);
        add_record(1, 1, 31'h7FFFFFFF, 0, 1, 2, 1, 2, 3, 5, 3, 0, 1);
        add_record(1, 16, 31'h00018000, 31'h0000FFFF, 0, 0, 0, 0, 8, 31'h80, 31'h7F,
                   2, 0);
        while (pend_q.size() != 0 || s_tvalid || matrix_q.size() != 0) @(posedge aclk);

        run_random(0, 0, 125, 1'b0);
        run_random(63, 0, 125, 1'b0);
        run_random(0, 63, 125, 1'b0);
        run_random(0, 0, 60, 1'b1);   // long receiver hold-off
        run_random(8, 8, 125, 1'b0);

        repeat (60) @(posedge aclk);
        $display("Sent %0d record bytes, checked %0d matrices (%0d zero-filled).",
                 bytes_in, records_seen, trunc_seen);
        $display("Input held back for %0d cycles during the receiver hold-off.",
                 stall_cycles);
        if (errors == 0 && matrix_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, matrix_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/smrp_pkg.sv
rtl/smrp_bit_engine.sv
rtl/smrp_seq.sv
rtl/swf_matrix_record_parser_top.sv
tb/tb_swf_matrix_record_parser_top.sv
